>>> rtl/sfdc_pkg.sv
// ----------------------------------------------------------------------------
// sfdc_pkg
// shared constants and types of the sync frame deframer with checksum
// ----------------------------------------------------------------------------
package sfdc_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    // body byte positions
    localparam logic [3:0] POS_ANGLE_LAST    = 4'd3;
    localparam logic [3:0] POS_CODE          = 4'd4;
    localparam logic [3:0] POS_VALUE_LAST    = 4'd6;
    localparam logic [3:0] POS_INTERVAL_LAST = 4'd8;
    localparam logic [3:0] POS_SEQUENCE      = 4'd9;
    localparam logic [3:0] POS_EMERGENCY     = 4'd10;
    localparam logic [3:0] POS_CHECKSUM      = 4'd11;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // one classified body byte
    typedef struct packed {
        logic [3:0] pos;
        logic [7:0] data;
    } body_entry_t;

endpackage

>>> rtl/sfdc_front.sv
// ----------------------------------------------------------------------------
// sfdc_front
// marker hunt and body byte classification
// ----------------------------------------------------------------------------
module sfdc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_ready,
    input  logic [7:0]           rx_byte,
    output logic                 push_valid,
    input  logic                 push_ready,
    output sfdc_pkg::body_entry_t push_entry
);

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        GATHER
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic       xfer;

    // hunt bytes are dropped, yet every byte waits for room in the queue
    assign rx_ready   = push_ready;
    assign xfer       = rx_valid && rx_ready;
    assign push_valid = rx_valid && (phase_reg == GATHER);
    assign push_entry = '{pos: pos_reg, data: rx_byte};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        if (xfer)
        begin
            case (phase_reg)
                HUNT_SECOND:
                begin
                    if (rx_byte == sfdc_pkg::SYNC_SECOND)
                    begin
                        phase_next = GATHER;
                        pos_next   = 4'd0;
                    end
                    else
                    begin
                        phase_next = HUNT_FIRST;
                    end
                end
                GATHER:
                begin
                    if (pos_reg >= sfdc_pkg::POS_CHECKSUM)
                    begin
                        phase_next = HUNT_FIRST;
                        pos_next   = 4'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == sfdc_pkg::SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HUNT_FIRST;
            pos_reg   <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

>>> rtl/sfdc_queue.sv
// ----------------------------------------------------------------------------
// sfdc_queue
// short register queue of classified body bytes
// ----------------------------------------------------------------------------
module sfdc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  sfdc_pkg::body_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output sfdc_pkg::body_entry_t pop_entry
);

    sfdc_pkg::body_entry_t                entry_reg [sfdc_pkg::QUEUE_DEPTH];
    logic [sfdc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [sfdc_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic                                 push_xfer, pop_xfer;

    assign push_ready = (count_reg != sfdc_pkg::QUEUE_CNT_W'(sfdc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign push_xfer  = push_valid && push_ready;
    assign pop_xfer   = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push_xfer)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_xfer)
            begin
                wr_ptr_reg <= wr_ptr_reg + sfdc_pkg::QUEUE_PTR_W'(1);
            end
            if (pop_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + sfdc_pkg::QUEUE_PTR_W'(1);
            end
            if (push_xfer && !pop_xfer)
            begin
                count_reg <= count_reg + sfdc_pkg::QUEUE_CNT_W'(1);
            end
            else if (pop_xfer && !push_xfer)
            begin
                count_reg <= count_reg - sfdc_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/sfdc_back.sv
// ----------------------------------------------------------------------------
// sfdc_back
// field assembly, checksum and emergency latch, registered result
// ----------------------------------------------------------------------------
module sfdc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  sfdc_pkg::body_entry_t pop_entry,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [31:0]           angle_bits,
    output logic [7:0]            param_code,
    output logic [15:0]           param_value,
    output logic [15:0]           interval_bits,
    output logic [7:0]            sequence_number,
    output logic [7:0]            frame_emergency,
    output logic [7:0]            held_emergency,
    output logic                  checksum_ok
);

    logic [31:0] angle_reg;
    logic [7:0]  code_reg;
    logic [15:0] value_reg;
    logic [15:0] interval_reg;
    logic [7:0]  sequence_reg;
    logic [7:0]  emergency_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  latched_reg;
    logic        res_valid_reg;
    logic        is_checksum, xfer;
    logic [3:0]  pos;
    logic [7:0]  data;

    assign pos         = pop_entry.pos;
    assign data        = pop_entry.data;
    assign is_checksum = (pos >= sfdc_pkg::POS_CHECKSUM);
    // body bytes always drain; the checksum byte needs a free result slot
    assign pop_ready   = !is_checksum || !res_valid_reg || res_ready;
    assign xfer        = pop_valid && pop_ready;
    assign res_valid   = res_valid_reg;

    // field holds and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= '0;
            code_reg      <= '0;
            value_reg     <= '0;
            interval_reg  <= '0;
            sequence_reg  <= '0;
            emergency_reg <= '0;
            sum_reg       <= '0;
            latched_reg   <= '0;
        end
        else if (xfer)
        begin
            if (is_checksum)
            begin
                sum_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_reg + data;
                if (pos inside {[4'd0:sfdc_pkg::POS_ANGLE_LAST]})
                begin
                    angle_reg <= {data, angle_reg[31:8]};
                end
                else if (pos == sfdc_pkg::POS_CODE)
                begin
                    code_reg <= data;
                end
                else if (pos <= sfdc_pkg::POS_VALUE_LAST)
                begin
                    value_reg <= {data, value_reg[15:8]};
                end
                else if (pos <= sfdc_pkg::POS_INTERVAL_LAST)
                begin
                    interval_reg <= {data, interval_reg[15:8]};
                end
                else if (pos == sfdc_pkg::POS_SEQUENCE)
                begin
                    sequence_reg <= data;
                end
                else
                begin
                    emergency_reg <= data;
                    if (latched_reg == 8'd0)
                    begin
                        latched_reg <= data;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (xfer && is_checksum)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer && is_checksum)
        begin
            angle_bits      <= angle_reg;
            param_code      <= code_reg;
            param_value     <= value_reg;
            interval_bits   <= interval_reg;
            sequence_number <= sequence_reg;
            frame_emergency <= emergency_reg;
            held_emergency  <= latched_reg;
            checksum_ok     <= (sum_reg == data);
        end
    end

endmodule

>>> rtl/sync_frame_deframer_checksum_unit.sv
// ----------------------------------------------------------------------------
// sync_frame_deframer_checksum_unit
// 0x55 0xAA framed deframer with 8-bit additive checksum
// ----------------------------------------------------------------------------
// result path: checksum byte into the queue, then into the result register
// throughput: one byte per cycle while the queue has room, set by the
//   single-byte front classifier and the back that drains one queue entry
//   per cycle while no checksum byte waits for a free result slot
// reset: rst_n asynchronous; hunt restarts, queue empties, emergency latch is zero
// ----------------------------------------------------------------------------
module sync_frame_deframer_checksum_unit (
    input  logic               clk,
    input  logic               rst_n,
    // byte stream
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    // frame results
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] angle_increment,
    output logic [7:0]         param_code,
    output logic [15:0]        param_value,
    output logic signed [15:0] sample_interval,
    output logic [7:0]         sequence_number,
    output logic [7:0]         frame_emergency,
    output logic [7:0]         held_emergency,
    output logic               checksum_ok
);

    // front to queue
    logic                  push_valid, push_ready;
    sfdc_pkg::body_entry_t push_entry;
    // queue to back
    logic                  pop_valid, pop_ready;
    sfdc_pkg::body_entry_t pop_entry;
    // raw field bits from the back
    logic [31:0]           angle_bits;
    logic [15:0]           interval_bits;

    // front: hunts the marker, tags body bytes with their position
    sfdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // queue decouples hunt from a stalled result side
    sfdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // back: gathers fields, checks sum, emits one transfer per frame
    sfdc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_entry       (pop_entry),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .angle_bits      (angle_bits),
        .param_code      (param_code),
        .param_value     (param_value),
        .interval_bits   (interval_bits),
        .sequence_number (sequence_number),
        .frame_emergency (frame_emergency),
        .held_emergency  (held_emergency),
        .checksum_ok     (checksum_ok)
    );

    // signed views of the little-endian fields
    assign angle_increment = $signed(angle_bits);
    assign sample_interval = $signed(interval_bits);

endmodule

>>> sim/sfdc_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfdc_frame_checker
// follows the accepted byte stream, deframes it on its own and compares every
// result transfer with the oldest frame it expects
// ----------------------------------------------------------------------------
module sfdc_frame_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic signed [31:0] angle_increment,
    input  logic [7:0]         param_code,
    input  logic [15:0]        param_value,
    input  logic signed [15:0] sample_interval,
    input  logic [7:0]         sequence_number,
    input  logic [7:0]         frame_emergency,
    input  logic [7:0]         held_emergency,
    input  logic               checksum_ok,
    output int unsigned        mismatches,
    output int unsigned        pending
);

    typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, GATHER} hunt_t;

    typedef struct {
        logic signed [31:0] angle;
        logic [7:0]         code;
        logic [15:0]        value;
        logic signed [15:0] interval;
        logic [7:0]         seq;
        logic [7:0]         emergency;
        logic [7:0]         held;
        logic               ok;
    } frame_t;

    hunt_t       hunt;
    logic [3:0]  body_pos;
    logic [31:0] angle_sr;
    logic [7:0]  code_q;
    logic [15:0] value_sr;
    logic [15:0] interval_sr;
    logic [7:0]  seq_q;
    logic [7:0]  emergency_q;
    logic [7:0]  body_sum;
    logic [7:0]  held_q;
    frame_t      frames_due[$];
    int unsigned miss_count;

    function automatic string frame_text(input frame_t f);
        return $sformatf({"angle=%0d code=%02h value=%04h interval=%0d ",
                          "seq=%02h emerg=%02h held=%02h ok=%0b"},
                         f.angle, f.code, f.value, f.interval, f.seq, f.emergency,
                         f.held, f.ok);
    endfunction

    // one accepted byte through the deframer
    task automatic deframe_byte(input logic [7:0] b);
        frame_t f;
        case (hunt)
            SEEK_SECOND:
            begin
                if (b == sfdc_pkg::SYNC_SECOND)
                begin
                    hunt     = GATHER;
                    body_pos = '0;
                    body_sum = '0;
                end
                else
                    hunt = SEEK_FIRST;
            end
            GATHER:
            begin
                if (body_pos < sfdc_pkg::POS_CHECKSUM)
                begin
                    body_sum = body_sum + b;
                    if (body_pos <= sfdc_pkg::POS_ANGLE_LAST)
                        angle_sr = {b, angle_sr[31:8]};
                    else if (body_pos == sfdc_pkg::POS_CODE)
                        code_q = b;
                    else if (body_pos <= sfdc_pkg::POS_VALUE_LAST)
                        value_sr = {b, value_sr[15:8]};
                    else if (body_pos <= sfdc_pkg::POS_INTERVAL_LAST)
                        interval_sr = {b, interval_sr[15:8]};
                    else if (body_pos == sfdc_pkg::POS_SEQUENCE)
                        seq_q = b;
                    else
                    begin
                        emergency_q = b;
                        if (held_q == 8'h00)
                            held_q = b;
                    end
                    body_pos = body_pos + 4'd1;
                end
                else
                begin
                    f.angle     = angle_sr;
                    f.code      = code_q;
                    f.value     = value_sr;
                    f.interval  = interval_sr;
                    f.seq       = seq_q;
                    f.emergency = emergency_q;
                    f.held      = held_q;
                    f.ok        = (body_sum == b);
                    frames_due.push_back(f);
                    hunt     = SEEK_FIRST;
                    body_pos = '0;
                    body_sum = '0;
                end
            end
            default:
                hunt = (b == sfdc_pkg::SYNC_FIRST) ? SEEK_SECOND : SEEK_FIRST;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_t want;
        frame_t got;
        if (!rst_n)
        begin
            hunt        = SEEK_FIRST;
            body_pos    = '0;
            angle_sr    = '0;
            code_q      = '0;
            value_sr    = '0;
            interval_sr = '0;
            seq_q       = '0;
            emergency_q = '0;
            body_sum    = '0;
            held_q      = '0;
            miss_count  = 0;
            frames_due.delete();
        end
        else
        begin
            if (rx_valid && rx_ready)
                deframe_byte(rx_byte);
            if (res_valid && res_ready)
            begin
                got.angle     = angle_increment;
                got.code      = param_code;
                got.value     = param_value;
                got.interval  = sample_interval;
                got.seq       = sequence_number;
                got.emergency = frame_emergency;
                got.held      = held_emergency;
                got.ok        = checksum_ok;
                if (frames_due.size() == 0)
                begin
                    if (miss_count < 10)
                        $display("%0t: unexpected result %s", $realtime, frame_text(got));
                    miss_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.angle !== want.angle || got.code !== want.code ||
                        got.value !== want.value || got.interval !== want.interval ||
                        got.seq !== want.seq || got.emergency !== want.emergency ||
                        got.held !== want.held || got.ok !== want.ok)
                    begin
                        if (miss_count < 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected %s", frame_text(want));
                            $display("  actual   %s", frame_text(got));
                        end
                        miss_count++;
                    end
                end
            end
        end
        mismatches <= miss_count;
        pending    <= frames_due.size();
    end

endmodule

>>> sim/tb_sync_frame_deframer_checksum_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_frame_deframer_checksum_unit
// drives framed and unframed byte streams into the deframer with random idle
// bursts on both channels; the checker beside the block predicts the frames
// ----------------------------------------------------------------------------
module tb_sync_frame_deframer_checksum_unit;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int ITEM_TARGET    = 1700;
    // last stretch of the run goes without idling
    localparam int CALM_FROM      = 1450;
    // long result hold-off that backs the block up into its input
    localparam int SQUEEZE_AT     = 400;
    localparam int SQUEEZE_CYCLES = 500;
    localparam int TAIL_CYCLES    = 20;
    localparam int LIMIT_CYCLES   = 400000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               rx_valid  = 1'b0;
    logic               rx_ready;
    logic [7:0]         rx_byte   = 8'h00;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic signed [31:0] angle_increment;
    logic [7:0]         param_code;
    logic [15:0]        param_value;
    logic signed [15:0] sample_interval;
    logic [7:0]         sequence_number;
    logic [7:0]         frame_emergency;
    logic [7:0]         held_emergency;
    logic               checksum_ok;

    int unsigned mismatches;
    int unsigned pending;

    // bytes transferred so far, shared with the receiver side
    int          sent_count  = 0;
    // sender idles with a chance of one in this many per byte, zero for none
    int          tx_gap_odds = 0;
    bit          calm        = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sync_frame_deframer_checksum_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_ready        (rx_ready),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .angle_increment (angle_increment),
        .param_code      (param_code),
        .param_value     (param_value),
        .sample_interval (sample_interval),
        .sequence_number (sequence_number),
        .frame_emergency (frame_emergency),
        .held_emergency  (held_emergency),
        .checksum_ok     (checksum_ok)
    );

    sfdc_frame_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_ready        (rx_ready),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .angle_increment (angle_increment),
        .param_code      (param_code),
        .param_value     (param_value),
        .sample_interval (sample_interval),
        .sequence_number (sequence_number),
        .frame_emergency (frame_emergency),
        .held_emergency  (held_emergency),
        .checksum_ok     (checksum_ok),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    // one byte transfer, maybe after an idle burst; valid stays up between
    // back-to-back bytes so it is never dropped and raised in one step
    task automatic send_byte(input logic [7:0] b);
        if (!calm && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        rx_byte  <= b;
        rx_valid <= 1'b1;
        do
            @(posedge clk);
        while (rx_ready !== 1'b1);
        sent_count++;
    endtask

    // marker, eleven body bytes and the additive checksum, spoiled on request
    task automatic send_frame(input logic [7:0] body [11], input bit spoil);
        logic [7:0] checksum;
        checksum = 8'h00;
        send_byte(sfdc_pkg::SYNC_FIRST);
        send_byte(sfdc_pkg::SYNC_SECOND);
        foreach (body[i])
        begin
            checksum = checksum + body[i];
            send_byte(body[i]);
        end
        if (spoil)
            checksum = checksum + 8'($urandom_range(1, 255));
        send_byte(checksum);
    endtask

    // body byte leaning toward the sign and range edges
    function automatic logic [7:0] field_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        logic [7:0] body [11];
        int         choice;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // doubled first marker byte must not sync: 0x55 0x55 0xaa is dropped
        send_byte(sfdc_pkg::SYNC_FIRST);
        send_byte(sfdc_pkg::SYNC_FIRST);
        send_byte(sfdc_pkg::SYNC_SECOND);
        // good frame: most negative angle, full value, largest interval,
        // no emergency yet so the held code still reads zero
        body = '{8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h00};
        send_frame(body, 1'b0);
        // bad checksum carrying the first emergency: still latched
        body = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'hFF};
        send_frame(body, 1'b1);

        while (sent_count < ITEM_TARGET)
        begin
            if (sent_count >= CALM_FROM)
                calm = 1'b1;
            // some stretches run without sender gaps at all
            tx_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 24);
            choice = $urandom_range(0, 9);
            if (choice < 8)
            begin
                foreach (body[i])
                    body[i] = field_byte();
                // emergency mostly clear, now and then a code
                if ($urandom_range(0, 3) != 0)
                    body[10] = 8'h00;
                send_frame(body, $urandom_range(0, 5) == 0);
            end
            else if (choice == 8)
            begin
                // broken or doubled marker, or a marker and a truncated body
                send_byte(sfdc_pkg::SYNC_FIRST);
                case ($urandom_range(0, 2))
                    0: send_byte(sfdc_pkg::SYNC_FIRST);
                    1: send_byte(8'($urandom));
                    default:
                    begin
                        send_byte(sfdc_pkg::SYNC_SECOND);
                        repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
                    end
                endcase
            end
            else
            begin
                // line noise
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            end
        end
        rx_valid <= 1'b0;

        // let the checker count the last transfer, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result side: random hold-off bursts in some stretches, one long
    // squeeze that fills the block, and no gaps once the run turns calm
    initial
    begin : receiver
        int gap;
        int odds;
        int stretch;
        bit squeezed;
        odds     = 0;
        stretch  = 0;
        squeezed = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stretch == 0)
            begin
                stretch = $urandom_range(20, 80);
                odds    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
            end
            stretch--;
            if (!squeezed && sent_count >= SQUEEZE_AT)
            begin
                squeezed = 1'b1;
                res_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                res_ready <= 1'b1;
            end
            else if (!calm && odds != 0 && $urandom_range(1, odds) == 1)
            begin
                gap = $urandom_range(1, 18);
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // hang guard
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/sfdc_pkg.sv
rtl/sfdc_front.sv
rtl/sfdc_queue.sv
rtl/sfdc_back.sv
rtl/sync_frame_deframer_checksum_unit.sv
sim/sfdc_frame_checker.sv
sim/tb_sync_frame_deframer_checksum_unit.sv
